// ===== rtl/spi_pkg.sv =====
package spi_pkg;

  localparam int MAX_SPS_DEF = 64;
  localparam int CFG_W       = 7;
  localparam int PHASE_W     = 16;
  localparam int FREQ_W      = 23;
  localparam int FRAC_W      = 8;
  localparam int ACC_W       = PHASE_W + FRAC_W;
  localparam int DIV_BITS    = 4;
  localparam int DIV_ITERS   = ACC_W / DIV_BITS;
  localparam int DIV_CNT_W   = $clog2(DIV_ITERS);
  localparam int Q_DEPTH     = 2;
  localparam int Q_PTR_W     = $clog2(Q_DEPTH);
  localparam int OUT_DATA_W  = ((PHASE_W + FREQ_W + 7) / 8) * 8;

  localparam logic [CFG_W-1:0]  SPS_RESET = CFG_W'(4);
  localparam logic [FREQ_W-1:0] FREQ_MAX  = {1'b0, {(FREQ_W-1){1'b1}}};
  localparam logic [FREQ_W-1:0] FREQ_MIN  = {1'b1, {(FREQ_W-1){1'b0}}};

  typedef struct packed {
    logic [PHASE_W-1:0] base;
    logic [FREQ_W-1:0]  step;
    logic [CFG_W-1:0]   sps;
  } entry_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

endpackage

// ===== rtl/symbol_phase_interpolator_core.sv =====
// Throughput: one sample per cycle while out_tready holds and the queue has an
// entry; the front end takes no new symbol while its radix-16 step divider runs
// or while its entry waits for queue space.
// Reset: synchronous, active low; samples_per_symbol returns to 4, the queue
// empties and the next symbol only primes the previous phase.
module symbol_phase_interpolator_core #(
  parameter int MAX_SPS = spi_pkg::MAX_SPS_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_tvalid,
  output logic                           in_tready,
  input  logic [spi_pkg::PHASE_W-1:0]    in_tdata,   // symbol_phase
  output logic                           out_tvalid,
  input  logic                           out_tready,
  output logic [spi_pkg::OUT_DATA_W-1:0] out_tdata,  // sample_phase, sample_freq
  output logic                           out_tlast,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [spi_pkg::CFG_W-1:0]      cfg_data
);
  import spi_pkg::*;

  logic    q_push;
  logic    q_pop;
  entry_t  q_entry;
  entry_t  q_head;
  q_stat_t q_stat;

  assign cfg_ready = 1'b1;

  spi_front #(
    .MAX_SPS(MAX_SPS)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_tvalid(in_tvalid),
    .in_tready(in_tready),
    .in_tdata (in_tdata),
    .cfg_valid(cfg_valid),
    .cfg_data (cfg_data),
    .q_stat   (q_stat),
    .q_push   (q_push),
    .q_entry  (q_entry)
  );

  spi_queue u_queue (
    .clk    (clk),
    .rst_n  (rst_n),
    .q_push (q_push),
    .q_entry(q_entry),
    .q_pop  (q_pop),
    .q_head (q_head),
    .q_stat (q_stat)
  );

  spi_back #(
    .MAX_SPS(MAX_SPS)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_head    (q_head),
    .q_stat    (q_stat),
    .q_pop     (q_pop),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tlast (out_tlast)
  );

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    q_push |-> !q_stat.full)
    else $error("queue written while full");

  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> !q_stat.empty)
    else $error("queue read while empty");

  a_run_continues: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tready && !out_tlast |=>
      out_tvalid && (out_tdata[PHASE_W +: FREQ_W] == $past(out_tdata[PHASE_W +: FREQ_W])))
    else $error("sample run broken or step changed within a symbol");

endmodule

// ===== rtl/spi_front.sv =====
module spi_front #(
  parameter int MAX_SPS = spi_pkg::MAX_SPS_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_tvalid,
  output logic                        in_tready,
  input  logic [spi_pkg::PHASE_W-1:0] in_tdata,
  input  logic                        cfg_valid,
  input  logic [spi_pkg::CFG_W-1:0]   cfg_data,
  input  spi_pkg::q_stat_t            q_stat,
  output logic                        q_push,
  output spi_pkg::entry_t             q_entry
);
  import spi_pkg::*;

  localparam int SPS_W = $clog2(MAX_SPS + 1);
  localparam logic [1:0] F_IDLE = 2'd0;
  localparam logic [1:0] F_DIV  = 2'd1;
  localparam logic [1:0] F_PUSH = 2'd2;
  localparam logic [ACC_W-1:0] Q_POS_LIM = ACC_W'(2**(FREQ_W-1) - 1);
  localparam logic [ACC_W-1:0] Q_NEG_LIM = ACC_W'(2**(FREQ_W-1));

  logic [1:0]           state_r, state_nxt;
  logic [PHASE_W-1:0]   prev_r, prev_nxt;
  logic                 prev_valid_r, prev_valid_nxt;
  logic [CFG_W-1:0]     cfg_r, cfg_nxt;
  logic [SPS_W-1:0]     sps_r, sps_nxt;
  logic                 neg_r, neg_nxt;
  logic [PHASE_W-1:0]   base_r, base_nxt;
  logic [ACC_W-1:0]     dq_r, dq_nxt;
  logic [SPS_W-1:0]     rem_r, rem_nxt;
  logic [DIV_CNT_W-1:0] cnt_r, cnt_nxt;

  logic                 accept;
  logic [PHASE_W-1:0]   diff;
  logic [PHASE_W-1:0]   mag;
  logic [SPS_W-1:0]     sps_eff;
  logic [ACC_W-1:0]     dq_div;
  logic [SPS_W-1:0]     rem_div;
  logic [FREQ_W-1:0]    step_sat;

  assign in_tready = (state_r == F_IDLE);
  assign accept    = in_tvalid && in_tready;
  assign diff      = in_tdata - prev_r;
  assign mag       = diff[PHASE_W-1] ? (~diff + PHASE_W'(1)) : diff;

  always_comb begin
    if (cfg_r == '0) begin
      sps_eff = SPS_W'(1);
    end else if (cfg_r > CFG_W'(MAX_SPS)) begin
      sps_eff = SPS_W'(MAX_SPS);
    end else begin
      sps_eff = SPS_W'(cfg_r);
    end
  end

  always_comb begin
    logic [SPS_W:0]     sh;
    logic [SPS_W-1:0]   rem_v;
    logic [ACC_W-1:0]   dq_v;
    rem_v = rem_r;
    dq_v  = dq_r;
    for (int k = 0; k < DIV_BITS; k++) begin
      sh   = {rem_v, dq_v[ACC_W-1]};
      dq_v = {dq_v[ACC_W-2:0], 1'b0};
      if (sh >= {1'b0, sps_r}) begin
        rem_v   = SPS_W'(sh - {1'b0, sps_r});
        dq_v[0] = 1'b1;
      end else begin
        rem_v = sh[SPS_W-1:0];
      end
    end
    rem_div = rem_v;
    dq_div  = dq_v;
  end

  always_comb begin
    logic [ACC_W-1:0] neg_q;
    neg_q = ~dq_r + ACC_W'(1);
    if (!neg_r) begin
      step_sat = (dq_r > Q_POS_LIM) ? FREQ_MAX : dq_r[FREQ_W-1:0];
    end else begin
      step_sat = (dq_r > Q_NEG_LIM) ? FREQ_MIN : neg_q[FREQ_W-1:0];
    end
  end

  assign q_push       = (state_r == F_PUSH) && !q_stat.full;
  assign q_entry.base = base_r;
  assign q_entry.step = step_sat;
  assign q_entry.sps  = CFG_W'(sps_r);

  always_comb begin
    state_nxt      = state_r;
    prev_nxt       = prev_r;
    prev_valid_nxt = prev_valid_r;
    cfg_nxt        = cfg_valid ? cfg_data : cfg_r;
    sps_nxt        = sps_r;
    neg_nxt        = neg_r;
    base_nxt       = base_r;
    dq_nxt         = dq_r;
    rem_nxt        = rem_r;
    cnt_nxt        = cnt_r;
    case (state_r)
      F_IDLE: begin
        if (accept) begin
          prev_nxt       = in_tdata;
          prev_valid_nxt = 1'b1;
          if (prev_valid_r) begin
            neg_nxt   = diff[PHASE_W-1];
            dq_nxt    = {mag, {FRAC_W{1'b0}}};
            rem_nxt   = '0;
            cnt_nxt   = '0;
            sps_nxt   = sps_eff;
            base_nxt  = prev_r;
            state_nxt = F_DIV;
          end
        end
      end
      F_DIV: begin
        dq_nxt  = dq_div;
        rem_nxt = rem_div;
        cnt_nxt = cnt_r + DIV_CNT_W'(1);
        if (cnt_r == DIV_CNT_W'(DIV_ITERS - 1)) begin
          state_nxt = F_PUSH;
        end
      end
      F_PUSH: begin
        if (q_push) begin
          state_nxt = F_IDLE;
        end
      end
      default: begin
        state_nxt = F_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= F_IDLE;
      prev_r       <= '0;
      prev_valid_r <= 1'b0;
      cfg_r        <= SPS_RESET;
      cnt_r        <= '0;
    end else begin
      state_r      <= state_nxt;
      prev_r       <= prev_nxt;
      prev_valid_r <= prev_valid_nxt;
      cfg_r        <= cfg_nxt;
      cnt_r        <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    sps_r  <= sps_nxt;
    neg_r  <= neg_nxt;
    base_r <= base_nxt;
    dq_r   <= dq_nxt;
    rem_r  <= rem_nxt;
  end

endmodule

// ===== rtl/spi_queue.sv =====
module spi_queue (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             q_push,
  input  spi_pkg::entry_t  q_entry,
  input  logic             q_pop,
  output spi_pkg::entry_t  q_head,
  output spi_pkg::q_stat_t q_stat
);
  import spi_pkg::*;

  entry_t             mem_r [Q_DEPTH];
  logic [Q_PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [Q_PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [Q_PTR_W:0]   count_r, count_nxt;

  assign q_head       = mem_r[rd_ptr_r];
  assign q_stat.full  = (count_r == (Q_PTR_W+1)'(Q_DEPTH));
  assign q_stat.empty = (count_r == '0);

  always_comb begin
    wr_ptr_nxt = q_push ? wr_ptr_r + Q_PTR_W'(1) : wr_ptr_r;
    rd_ptr_nxt = q_pop ? rd_ptr_r + Q_PTR_W'(1) : rd_ptr_r;
    count_nxt  = count_r;
    if (q_push && !q_pop) begin
      count_nxt = count_r + (Q_PTR_W+1)'(1);
    end else if (!q_push && q_pop) begin
      count_nxt = count_r - (Q_PTR_W+1)'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (q_push) begin
      mem_r[wr_ptr_r] <= q_entry;
    end
  end

endmodule

// ===== rtl/spi_back.sv =====
module spi_back #(
  parameter int MAX_SPS = spi_pkg::MAX_SPS_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  spi_pkg::entry_t                q_head,
  input  spi_pkg::q_stat_t               q_stat,
  output logic                           q_pop,
  output logic                           out_tvalid,
  input  logic                           out_tready,
  output logic [spi_pkg::OUT_DATA_W-1:0] out_tdata,
  output logic                           out_tlast
);
  import spi_pkg::*;

  localparam int SPS_W = $clog2(MAX_SPS + 1);
  localparam int PAD_W = OUT_DATA_W - PHASE_W - FREQ_W;

  logic [SPS_W-1:0]   idx_r, idx_nxt;
  logic [ACC_W-1:0]   acc_r, acc_nxt;
  logic               valid_r, valid_nxt;
  logic [PHASE_W-1:0] phase_r;
  logic [FREQ_W-1:0]  freq_r;
  logic               last_r;

  logic               emit;
  logic               last;
  logic [ACC_W-1:0]   cur_acc;
  logic [ACC_W-1:0]   step_ext;

  assign emit     = !q_stat.empty && (!valid_r || out_tready);
  assign cur_acc  = (idx_r == '0) ? {q_head.base, {FRAC_W{1'b0}}} : acc_r;
  assign last     = ((CFG_W'(idx_r) + CFG_W'(1)) == q_head.sps);
  assign step_ext = {{(ACC_W-FREQ_W){q_head.step[FREQ_W-1]}}, q_head.step};
  assign q_pop    = emit && last;

  always_comb begin
    idx_nxt   = idx_r;
    acc_nxt   = acc_r;
    valid_nxt = out_tready ? 1'b0 : valid_r;
    if (emit) begin
      valid_nxt = 1'b1;
      acc_nxt   = cur_acc + step_ext;
      idx_nxt   = last ? '0 : idx_r + SPS_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r   <= '0;
      valid_r <= 1'b0;
    end else begin
      idx_r   <= idx_nxt;
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    acc_r <= acc_nxt;
    if (emit) begin
      phase_r <= cur_acc[ACC_W-1:FRAC_W];
      freq_r  <= q_head.step;
      last_r  <= last;
    end
  end

  assign out_tvalid = valid_r;
  assign out_tdata  = {{PAD_W{1'b0}}, freq_r, phase_r};
  assign out_tlast  = last_r;

endmodule

// ===== dv/phase_sample_checker.sv =====
`timescale 1ns / 1ps

module phase_sample_checker (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_tvalid,
  input  logic                           in_tready,
  input  logic [spi_pkg::PHASE_W-1:0]    in_tdata,   // symbol_phase
  input  logic                           out_tvalid,
  input  logic                           out_tready,
  input  logic [spi_pkg::OUT_DATA_W-1:0] out_tdata,  // sample_phase, sample_freq
  input  logic                           out_tlast,
  input  logic                           cfg_valid,
  input  logic                           cfg_ready,
  input  logic [spi_pkg::CFG_W-1:0]      cfg_data,
  output int                             mismatches,
  output int                             pending,
  output int                             samples_seen
);
  import spi_pkg::*;

  localparam int STEP_HI = (1 << (FREQ_W - 1)) - 1;
  localparam int STEP_LO = -(1 << (FREQ_W - 1));

  typedef struct packed {
    logic [PHASE_W-1:0] phase;
    logic [FREQ_W-1:0]  freq;
    logic               last;
  } sample_t;

  sample_t            expected_samples[$];
  logic [CFG_W-1:0]   sps_setting;
  logic [PHASE_W-1:0] prev_phase;
  logic               prev_seen;

  function automatic int samples_per_symbol(input logic [CFG_W-1:0] s);
    int n;
    n = s;
    if (n == 0) n = 1;
    if (n > MAX_SPS_DEF) n = MAX_SPS_DEF;
    return n;
  endfunction

  task automatic interpolate_symbol(input logic [PHASE_W-1:0] ph);
    int                 n;
    int                 diff;
    int                 step;
    logic [PHASE_W-1:0] d;
    logic [ACC_W-1:0]   acc;
    sample_t            s;
    if (!prev_seen) begin
      prev_phase = ph;
      prev_seen  = 1'b1;
      return;
    end
    n    = samples_per_symbol(sps_setting);
    d    = ph - prev_phase;
    diff = $signed(d);
    step = (diff * (1 << FRAC_W)) / n;
    if (step > STEP_HI) step = STEP_HI;
    if (step < STEP_LO) step = STEP_LO;
    acc = {prev_phase, {FRAC_W{1'b0}}};
    for (int i = 0; i < n; i++) begin
      s.phase = acc[ACC_W-1:FRAC_W];
      s.freq  = step[FREQ_W-1:0];
      s.last  = (i == n - 1);
      expected_samples.push_back(s);
      acc = acc + ACC_W'(step);
    end
    prev_phase = ph;
  endtask

  task automatic check_sample();
    sample_t got;
    sample_t want;
    got.phase = out_tdata[PHASE_W-1:0];
    got.freq  = out_tdata[PHASE_W+FREQ_W-1:PHASE_W];
    got.last  = out_tlast;
    samples_seen++;
    if (expected_samples.size() == 0) begin
      if (mismatches < 10)
        $display("%0t: unexpected sample phase %h freq %h last %b",
                 $time, got.phase, got.freq, got.last);
      mismatches++;
      return;
    end
    want = expected_samples.pop_front();
    if (got.phase !== want.phase || got.freq !== want.freq || got.last !== want.last) begin
      if (mismatches < 10)
        $display("%0t: sample mismatch: expected phase %h freq %h last %b, %s %h %s %h %s %b",
                 $time, want.phase, want.freq, want.last,
                 "got phase", got.phase, "freq", got.freq, "last", got.last);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      expected_samples.delete();
      sps_setting = SPS_RESET;
      prev_phase  = '0;
      prev_seen   = 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) sps_setting = cfg_data;
      if (in_tvalid && in_tready) interpolate_symbol(in_tdata);
      if (out_tvalid && out_tready) check_sample();
    end
    pending <= expected_samples.size();
  end

endmodule

// ===== dv/tb_symbol_phase_interpolator_core.sv =====
`timescale 1ns / 1ps

module tb_symbol_phase_interpolator_core;
  import spi_pkg::*;

  localparam int HALF_PERIOD = 4;
  localparam int CYCLE_LIMIT = 3_000_000;
  localparam int SETTLE      = 24;
  localparam int SEGMENTS    = 9;
  localparam int SEG_ITEMS   = 28;

  logic                  clk        = 1'b0;
  logic                  rst_n      = 1'b0;
  logic                  in_tvalid  = 1'b0;
  logic [PHASE_W-1:0]    in_tdata   = '0;
  logic                  out_tready = 1'b0;
  logic                  cfg_valid  = 1'b0;
  logic [CFG_W-1:0]      cfg_data   = '0;
  logic                  in_tready;
  logic                  out_tvalid;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic                  out_tlast;
  logic                  cfg_ready;

  int mismatches;
  int pending;
  int samples_seen;
  int cycles         = 0;
  int tx_idle_pct    = 0;
  int rx_stall_pct   = 0;
  int symbols_sent   = 0;
  int settings_used  = 0;
  logic [PHASE_W-1:0] last_phase = '0;

  always #HALF_PERIOD clk = ~clk;

  symbol_phase_interpolator_core u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data)
  );

  phase_sample_checker u_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_tvalid    (in_tvalid),
    .in_tready    (in_tready),
    .in_tdata     (in_tdata),
    .out_tvalid   (out_tvalid),
    .out_tready   (out_tready),
    .out_tdata    (out_tdata),
    .out_tlast    (out_tlast),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_data     (cfg_data),
    .mismatches   (mismatches),
    .pending      (pending),
    .samples_seen (samples_seen)
  );

  always @(posedge clk) begin
    out_tready <= ($urandom_range(99) >= rx_stall_pct);
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("tb_symbol_phase_interpolator_core: FAIL");
      $finish;
    end
  end

  task automatic send_symbol(input logic [PHASE_W-1:0] ph);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= ph;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    last_phase = ph;
    symbols_sent++;
  endtask

  task automatic wait_drained();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_sps(input logic [CFG_W-1:0] v);
    wait_drained();
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    settings_used++;
  endtask

  function automatic logic [PHASE_W-1:0] pick_phase(input logic [PHASE_W-1:0] prev);
    int unsigned        r;
    logic [PHASE_W-1:0] ph;
    r = $urandom_range(9);
    if (r < 5)      ph = PHASE_W'($urandom());
    else if (r < 8) ph = prev + PHASE_W'($urandom_range(64)) - PHASE_W'(32);
    else if (r < 9) ph = prev ^ {1'b1, {(PHASE_W-1){1'b0}}};
    else            ph = prev + ($urandom_range(1) ? PHASE_W'(16'h7FFF) : PHASE_W'(16'h8001));
    return ph;
  endfunction

  initial begin
    logic [CFG_W-1:0] seg_sps[SEGMENTS];
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // default setting, first symbol primes
    tx_idle_pct  = 14;
    rx_stall_pct = 82;
    send_symbol(16'h0000);
    send_symbol(16'h8000);
    send_symbol(16'h7FFF);
    send_symbol(16'h8000);
    send_symbol(16'hFFFF);
    send_symbol(16'h0000);
    send_symbol(16'h0001);
    send_symbol(16'hFFFF);
    // truncation of negative steps toward zero
    write_sps(7'd3);
    send_symbol(16'h0000);
    send_symbol(16'hFFFF);
    send_symbol(16'h0005);
    send_symbol(16'h0000);
    // step saturation both ways, then rate codes 0, 127, 64 and 65
    write_sps(7'd1);
    send_symbol(16'h7FFF);
    send_symbol(16'hFFFF);
    send_symbol(16'h0123);
    write_sps(7'd0);
    send_symbol(16'h8123);
    send_symbol(16'h1000);
    write_sps(7'd127);
    send_symbol(16'h9000);
    send_symbol(16'h8FFF);
    write_sps(7'd64);
    send_symbol(16'h0F00);
    send_symbol(16'h7F00);
    write_sps(7'd65);
    send_symbol(16'h4000);

    seg_sps = '{7'd2, 7'd64, 7'd0, 7'd1, 7'd127, 7'd8,
                CFG_W'($urandom_range(1, 16)), 7'd65, CFG_W'($urandom_range(127))};
    for (int seg = 0; seg < SEGMENTS; seg++) begin
      if (seg < 3) begin
        tx_idle_pct  = 14;
        rx_stall_pct = 82;
      end else if (seg < 6) begin
        tx_idle_pct  = 82;
        rx_stall_pct = 14;
      end else begin
        tx_idle_pct  = 0;
        rx_stall_pct = 0;
      end
      write_sps(seg_sps[seg]);
      for (int k = 0; k < SEG_ITEMS; k++) begin
        if ($urandom_range(39) == 0) wait_drained();
        send_symbol(pick_phase(last_phase));
      end
    end

    wait_drained();
    $display("covered %0d symbols and %0d samples across %0d rate settings",
             symbols_sent, samples_seen, settings_used + 1);
    $display("including rate codes 0, 1, 64, 65 and 127 with both-side stalls");
    if (mismatches == 0 && pending == 0) begin
      $display("tb_symbol_phase_interpolator_core: PASS");
    end else begin
      $display("tb_symbol_phase_interpolator_core: FAIL");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/spi_pkg.sv
rtl/spi_front.sv
rtl/spi_queue.sv
rtl/spi_back.sv
rtl/symbol_phase_interpolator_core.sv
dv/phase_sample_checker.sv
dv/tb_symbol_phase_interpolator_core.sv
